// File: hw/rtl/ipv6_address_validator_assert.svh
// Assertion macros shared by the validator RTL.
// No dependencies; included by the queue and parser modules.
`ifndef IPV6_ADDRESS_VALIDATOR_ASSERT_SVH
`define IPV6_ADDRESS_VALIDATOR_ASSERT_SVH

// expression holds at every edge out of reset
`define IPVAV_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define IPVAV_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the cycle after
`define IPVAV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ipvav_pkg.sv
// Shared types and constants for the IPv6 address text validator.
// No dependencies.
`timescale 1ns / 1ps

package ipvav_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int OCTET_MAX     = 255;
  localparam int GROUPS_FULL   = 8;
  localparam int GROUP_LEN_MAX = 4;
  localparam int OCTETS_FULL   = 4;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  localparam logic [3:0] ST_NONE         = 4'd0;
  localparam logic [3:0] ST_VALID        = 4'd0;
  localparam logic [3:0] ST_LOOPBACK     = 4'd1;
  localparam logic [3:0] ST_LEAD_COLON   = 4'd2;
  localparam logic [3:0] ST_LONG_GROUP   = 4'd3;
  localparam logic [3:0] ST_TRAIL_COLON  = 4'd4;
  localparam logic [3:0] ST_TRIPLE_COLON = 4'd5;
  localparam logic [3:0] ST_DOUBLE_DOT   = 4'd6;
  localparam logic [3:0] ST_TRAIL_DOT    = 4'd7;
  localparam logic [3:0] ST_OCTET_RANGE  = 4'd8;
  localparam logic [3:0] ST_ILLEGAL      = 4'd9;
  localparam logic [3:0] ST_OCTETS_MANY  = 4'd10;
  localparam logic [3:0] ST_OCTETS_FEW   = 4'd11;
  localparam logic [3:0] ST_GROUPS_MANY  = 4'd12;
  localparam logic [3:0] ST_GROUPS_FEW   = 4'd13;

  // one classified character beat
  typedef struct packed {
    logic       is_dig;
    logic       is_letter;
    logic       is_colon;
    logic       is_dot;
    logic [3:0] digit;
    logic       last;
  } cls_t;

endpackage

// File: hw/rtl/ipvav_front.sv
// Input side: accepts character beats and classifies them for the queue.
// Depends on ipvav_pkg.
`timescale 1ns / 1ps

module ipvav_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    ch,
  input  logic          last_char,
  input  logic          q_full,
  output logic          push,
  output ipvav_pkg::cls_t beat
);
  import ipvav_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    beat.is_dig    = (ch >= CH_0) && (ch <= CH_9);
    beat.is_letter = ((ch >= CH_LA) && (ch <= CH_LF)) || ((ch >= CH_UA) && (ch <= CH_UF));
    beat.is_colon  = (ch == CH_COLON);
    beat.is_dot    = (ch == CH_DOT);
    beat.digit     = ch[3:0];
    beat.last      = last_char;
  end

endmodule

// File: hw/rtl/ipvav_queue.sv
// Short queue of classified beats between the front and the parser.
// Depends on ipvav_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "ipv6_address_validator_assert.svh"

module ipvav_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ipvav_pkg::cls_t wr_beat,
  input  logic            pop,
  output logic            full,
  output logic            q_valid,
  output ipvav_pkg::cls_t rd_beat
);
  import ipvav_pkg::*;

  cls_t                   mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign rd_beat = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_beat;
  end

  `IPVAV_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count overflow")
  `IPVAV_ASSERT_IMPL(a_pop_nonempty, clk, rst, pop, count != '0, "pop from empty queue")

endmodule

// File: hw/rtl/ipvav_back.sv
// Parser: walks the address phases and registers the status, one queued beat
// a cycle; a stalled status holds a last beat. Uses ipvav_pkg, assert macros.
`timescale 1ns / 1ps
`include "ipv6_address_validator_assert.svh"

module ipvav_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  ipvav_pkg::cls_t beat,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [3:0]      status
);
  import ipvav_pkg::*;

  typedef enum logic [2:0] {
    PH_START, PH_HEX, PH_DBL, PH_COLON, PH_DOT, PH_DEC
  } phase_t;

  phase_t     phase, phase_next;
  logic       held, held_next;
  logic [5:0] group_count, group_count_next;
  logic [5:0] empty_count, empty_count_next;
  logic [2:0] group_len, group_len_next;
  logic [2:0] octet_count, octet_count_next;
  logic [8:0] octet_value, octet_value_next;
  logic       octet_stopped, octet_stopped_next;
  logic [1:0] loop_sum, loop_sum_next;
  logic       loop_spoiled, loop_spoiled_next;
  logic [3:0] first_error, first_error_next;
  logic [3:0] result;

  // {stopped, value}
  function automatic logic [9:0] octet_upd(input logic [8:0] v, input logic s,
                                           input cls_t c);
    logic [12:0] t;
    t = 13'(v) * 13'd10 + 13'(c.digit);
    if (s) return {s, v};
    if (!c.is_dig) return {1'b1, v};
    if (t > 13'(OCTET_MAX)) return {1'b0, 9'(OCTET_MAX + 1)};
    return {1'b0, t[8:0]};
  endfunction

  // {spoiled, sum}
  function automatic logic [2:0] loop_upd(input logic [1:0] sm, input logic sp,
                                          input cls_t c);
    logic [4:0] t;
    t = 5'(sm) + 5'(c.digit);
    if (sp) return {sp, sm};
    if (!c.is_dig) return {1'b1, sm};
    if (t > 5'd2) return {1'b0, 2'd2};
    return {1'b0, t[1:0]};
  endfunction

  assign pop = q_valid && (!beat.last || !out_valid || !out_stall);

  always_comb begin
    phase_t     ph_eff;
    logic       consume;
    logic       is_hex;
    logic [3:0] fc;
    logic [3:0] err;
    logic [2:0] oc_fin;
    logic [6:0] grp_sum;
    logic [6:0] grp_min;

    phase_next         = phase;
    held_next          = held;
    group_count_next   = group_count;
    empty_count_next   = empty_count;
    group_len_next     = group_len;
    octet_count_next   = octet_count;
    octet_value_next   = octet_value;
    octet_stopped_next = octet_stopped;
    loop_sum_next      = loop_sum;
    loop_spoiled_next  = loop_spoiled;
    first_error_next   = first_error;
    ph_eff             = phase;
    consume            = 1'b0;
    is_hex             = beat.is_dig || beat.is_letter;
    fc                 = ST_NONE;

    if (first_error == ST_NONE) begin
      if (held) begin
        held_next = 1'b0;
        if (beat.is_colon) begin
          if (empty_count != 6'd63) empty_count_next = empty_count + 6'd1;
          phase_next = PH_DBL;
        end else if (phase == PH_START) begin
          fc = ST_LEAD_COLON;
        end else begin
          phase_next = PH_COLON;
          ph_eff     = PH_COLON;
          consume    = 1'b1;
        end
      end else begin
        consume = 1'b1;
      end
    end

    if (consume) begin
      case (ph_eff)
        PH_START, PH_DBL, PH_COLON: begin
          if (is_hex) begin
            if (group_count != 6'd63) group_count_next = group_count + 6'd1;
            group_len_next = 3'd1;
            phase_next     = PH_HEX;
            {octet_stopped_next, octet_value_next} = octet_upd(9'd0, 1'b0, beat);
            {loop_spoiled_next, loop_sum_next} = loop_upd(loop_sum, loop_spoiled, beat);
          end else if (beat.is_colon) begin
            if (ph_eff != PH_START) fc = ST_TRIPLE_COLON;
            else if (beat.last) fc = ST_LEAD_COLON;
            else held_next = 1'b1;
          end else begin
            fc = ST_ILLEGAL;
          end
        end
        PH_HEX: begin
          if (is_hex) begin
            if (group_len < 3'd5) group_len_next = group_len + 3'd1;
            {octet_stopped_next, octet_value_next} =
              octet_upd(octet_value, octet_stopped, beat);
            {loop_spoiled_next, loop_sum_next} = loop_upd(loop_sum, loop_spoiled, beat);
          end else if (beat.is_dot) begin
            if (octet_value > 9'(OCTET_MAX)) fc = ST_OCTET_RANGE;
            else begin
              phase_next = PH_DOT;
              if (octet_count != 3'd7) octet_count_next = octet_count + 3'd1;
            end
          end else if (beat.is_colon) begin
            if (group_len > 3'(GROUP_LEN_MAX)) fc = ST_LONG_GROUP;
            else begin
              group_len_next = 3'd0;
              if (beat.last) fc = ST_TRAIL_COLON;
              else held_next = 1'b1;
            end
          end else begin
            fc = ST_ILLEGAL;
          end
        end
        PH_DOT: begin
          if (beat.is_dig) begin
            phase_next = PH_DEC;
            {octet_stopped_next, octet_value_next} = octet_upd(9'd0, 1'b0, beat);
          end else if (beat.is_dot) fc = ST_DOUBLE_DOT;
          else fc = ST_ILLEGAL;
        end
        PH_DEC: begin
          if (beat.is_dig) begin
            {octet_stopped_next, octet_value_next} =
              octet_upd(octet_value, octet_stopped, beat);
          end else if (beat.is_dot) begin
            if (octet_value > 9'(OCTET_MAX)) fc = ST_OCTET_RANGE;
            else if (beat.last) fc = ST_TRAIL_DOT;
            else begin
              phase_next = PH_DOT;
              if (octet_count != 3'd7) octet_count_next = octet_count + 3'd1;
            end
          end else begin
            fc = ST_ILLEGAL;
          end
        end
        default: fc = ST_ILLEGAL;
      endcase
    end

    if (fc != ST_NONE) begin
      first_error_next = fc;
      held_next        = 1'b0;
    end

    // end-of-address checks
    err    = first_error_next;
    oc_fin = octet_count_next;
    if (err == ST_NONE) begin
      if (phase_next == PH_HEX && group_len_next > 3'(GROUP_LEN_MAX)) err = ST_LONG_GROUP;
      else if (phase_next == PH_DEC) begin
        if (octet_value_next > 9'(OCTET_MAX)) err = ST_OCTET_RANGE;
        else if (octet_count_next != 3'd7) oc_fin = octet_count_next + 3'd1;
      end
    end
    grp_sum = 7'(empty_count_next) + 7'(group_count_next >> 1) + 7'(oc_fin);
    grp_min = 7'(oc_fin >> 1) + 7'(group_count_next);
    if (err != ST_NONE) result = err;
    else if (oc_fin > 3'(OCTETS_FULL)) result = ST_OCTETS_MANY;
    else if (oc_fin != 3'd0 && oc_fin < 3'(OCTETS_FULL)) result = ST_OCTETS_FEW;
    else if (grp_sum > 7'(GROUPS_FULL)) result = ST_GROUPS_MANY;
    else if (empty_count_next == 6'd0 && grp_min < 7'(GROUPS_FULL)) result = ST_GROUPS_FEW;
    else if (!loop_spoiled_next && loop_sum_next == 2'd1) result = ST_LOOPBACK;
    else result = ST_VALID;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      held          <= 1'b0;
      group_count   <= '0;
      empty_count   <= '0;
      group_len     <= '0;
      octet_count   <= '0;
      octet_value   <= '0;
      octet_stopped <= 1'b0;
      loop_sum      <= '0;
      loop_spoiled  <= 1'b0;
      first_error   <= ST_NONE;
      out_valid     <= 1'b0;
      status        <= ST_VALID;
    end else begin
      if (pop && beat.last) begin
        phase         <= PH_START;
        held          <= 1'b0;
        group_count   <= '0;
        empty_count   <= '0;
        group_len     <= '0;
        octet_count   <= '0;
        octet_value   <= '0;
        octet_stopped <= 1'b0;
        loop_sum      <= '0;
        loop_spoiled  <= 1'b0;
        first_error   <= ST_NONE;
        out_valid     <= 1'b1;
        status        <= result;
      end else begin
        if (pop) begin
          phase         <= phase_next;
          held          <= held_next;
          group_count   <= group_count_next;
          empty_count   <= empty_count_next;
          group_len     <= group_len_next;
          octet_count   <= octet_count_next;
          octet_value   <= octet_value_next;
          octet_stopped <= octet_stopped_next;
          loop_sum      <= loop_sum_next;
          loop_spoiled  <= loop_spoiled_next;
          first_error   <= first_error_next;
        end
        if (!out_stall) out_valid <= 1'b0;
      end
    end
  end

  `IPVAV_ASSERT_NEXT(a_reset_after_last, clk, rst, pop && beat.last, phase == PH_START && first_error == ST_NONE && !held, "parser not cleared after last beat")
  `IPVAV_ASSERT_NEXT(a_error_sticky, clk, rst, first_error != ST_NONE && !(pop && beat.last), first_error == $past(first_error), "first error overwritten")
  `IPVAV_ASSERT_IMPL(a_held_phase, clk, rst, held, phase == PH_START || phase == PH_HEX, "colon held in wrong phase")

endmodule

// File: hw/rtl/ipv6_address_validator.sv
// IPv6 address text validator.
// Channels: in_valid/in_stall carry ch and last_char, one character per beat;
// the beat with last_char high closes the address. out_valid/out_stall carry
// status, one beat per address: 0 valid, 1 loopback, 2..13 the first error.
// Throughput: one character per cycle while the output is not stalled, set
// by the parser step. The last character passes the queue entry and then
// the parser's status register before its status is offered.
// A stalled status holds in the output register; the parser then stops only
// at the next last beat, and the two-entry queue fills before in_stall rises.
// Reset (rst, synchronous) empties the queue, drops any pending status and
// returns the parser to the start of an address.
// Depends on ipvav_pkg, ipvav_front, ipvav_queue and ipvav_back.
`timescale 1ns / 1ps

module ipv6_address_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] status
);
  import ipvav_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_valid;
  cls_t wr_beat;
  cls_t rd_beat;

  ipvav_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .ch        (ch),
    .last_char (last_char),
    .q_full    (q_full),
    .push      (push),
    .beat      (wr_beat)
  );

  ipvav_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_beat (wr_beat),
    .pop     (pop),
    .full    (q_full),
    .q_valid (q_valid),
    .rd_beat (rd_beat)
  );

  ipvav_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .beat      (rd_beat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status)
  );

endmodule
